/* rtl/cc3d_pkg.sv */
// Shared types, constants and helper functions of the 3D circular convolution block.
// No dependencies; every other file of the block imports this package.
package cc3d_pkg;

	localparam int MAX_IMAGE_DIM_DEF  = 16;
	localparam int MAX_KERNEL_DIM_DEF = 7;

	localparam int ACT_W     = 2;
	localparam int ADDR_W    = 12;
	localparam int VAL_W     = 16;
	localparam int POS_W     = 4;
	localparam int SUM_W     = 40;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int ISZ_W     = 5;
	localparam int KSZ_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 5;
	localparam int MOD_W     = 2 * POS_W;

	localparam logic [ISZ_W-1:0] IMG_SIZE_RST = ISZ_W'(16);
	localparam logic [KSZ_W-1:0] KER_SIZE_RST = KSZ_W'(3);

	typedef enum logic [ACT_W-1:0] {
		ACT_KERNEL = 2'd0,
		ACT_IMAGE  = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMG_X = 3'd0,
		REG_IMG_Y = 3'd1,
		REG_IMG_Z = 3'd2,
		REG_KER_X = 3'd3,
		REG_KER_Y = 3'd4,
		REG_KER_Z = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_PREP,
		S_RUN,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic wr_kernel;
		logic wr_image;
		logic load_query;
		logic setup;
		logic prep;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic last;
		logic pipe_busy;
		logic out_busy;
	} sts_t;

	// position modulo image size, restoring subtraction over the position bits
	function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] p,
	                                             input logic [ISZ_W-1:0] n);
		logic [MOD_W-1:0] r;
		logic [MOD_W-1:0] d;
		r = MOD_W'(p);
		for (int k = POS_W - 1; k >= 0; k--) begin
			d = MOD_W'(n) << k;
			if (r >= d) r = r - d;
		end
		return r[POS_W-1:0];
	endfunction

endpackage

/* rtl/cc3d_if.sv */
// Valid/ready channel interfaces: request items in, result items out.
// Depends on cc3d_pkg for field widths.
interface cc3d_req_if import cc3d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [ADDR_W-1:0] address;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [POS_W-1:0]  pos_z;

	modport source (output valid, action, address, value, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, action, address, value, pos_x, pos_y, pos_z, output ready);
endinterface

interface cc3d_rsp_if import cc3d_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SUM_W-1:0] sum;
	logic                    bad_size;

	modport source (output valid, sum, bad_size, input ready);
	modport sink (input valid, sum, bad_size, output ready);
endinterface

/* rtl/cc3d_ctrl.sv */
// Controller state machine: accepts requests and sequences setup, taps and result.
// Depends on cc3d_pkg; drives the datapath through cmd_t and watches sts_t.
module cc3d_ctrl import cc3d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [ACT_W-1:0] req_action,
	output logic             req_ready,
	output cmd_t             cmd,
	input  sts_t             sts
);

	state_t state_q;
	state_t state_d;
	logic   acc_en;

	assign acc_en = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc_en && action_t'(req_action) == ACT_QUERY) begin
					state_d = sts.bad ? S_DONE : S_SETUP;
				end
			end
			S_SETUP: state_d = S_PREP;
			S_PREP:  state_d = S_RUN;
			S_RUN: begin
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				case (action_t'(req_action))
					ACT_KERNEL: cmd.wr_kernel = acc_en;
					ACT_IMAGE:  cmd.wr_image = acc_en;
					ACT_QUERY:  cmd.load_query = acc_en;
					default:    cmd = '0;
				endcase
			end
			S_SETUP: cmd.setup = 1'b1;
			S_PREP:  cmd.prep = 1'b1;
			S_RUN:   cmd.step = 1'b1;
			S_DRAIN: cmd = '0;
			S_DONE:  cmd.finish = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_query |=> (state_q == S_SETUP || state_q == S_DONE))
		else $error("query did not start setup or result");

	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && sts.last) |=> state_q == S_DRAIN)
		else $error("last tap did not move to drain");

endmodule

/* rtl/cc3d_dp.sv */
// Datapath: size registers, kernel and image memories, index walk, multiply-accumulate.
// Depends on cc3d_pkg and cc3d_if; commanded by cc3d_ctrl.
module cc3d_dp import cc3d_pkg::*; #(
	parameter int MAX_IMAGE_DIM  = MAX_IMAGE_DIM_DEF,
	parameter int MAX_KERNEL_DIM = MAX_KERNEL_DIM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data,
	input  logic [ADDR_W-1:0]       req_address,
	input  logic signed [VAL_W-1:0] req_value,
	input  logic [POS_W-1:0]        req_pos_x,
	input  logic [POS_W-1:0]        req_pos_y,
	input  logic [POS_W-1:0]        req_pos_z,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	cc3d_rsp_if.source              rsp
);

	localparam int IMG_FULL  = MAX_IMAGE_DIM * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
	localparam int ADDR_SPAN = 1 << ADDR_W;
	localparam int IMG_DEPTH = (IMG_FULL > ADDR_SPAN) ? ADDR_SPAN : IMG_FULL;
	localparam int KER_DEPTH = MAX_KERNEL_DIM * MAX_KERNEL_DIM * MAX_KERNEL_DIM;
	localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KER_AW    = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
	localparam int OFY_W     = 2 * POS_W;

	logic [ISZ_W-1:0] img_x_q, img_y_q, img_z_q;
	logic [KSZ_W-1:0] ker_x_q, ker_y_q, ker_z_q;
	logic [ISZ_W-1:0] nx, ny, nz;
	logic [KSZ_W-1:0] kxn, kyn, kzn;
	logic [KSZ_W-1:0] hx, hy, hz;
	logic             bad;

	logic signed [VAL_W-1:0] img_mem [IMG_DEPTH];
	logic signed [VAL_W-1:0] ker_mem [KER_DEPTH];

	logic [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic [POS_W-1:0]  jx0_q, jy0_q, jz0_q;
	logic [POS_W-1:0]  jx_q, jy_q, jz_q;
	logic [ISZ_W+POS_W-1:0] nxny_q;
	logic [OFY_W-1:0]  offy0_q, offyl_q, offy_q;
	logic [ADDR_W-1:0] offzl_q, offz_q;
	logic [KSZ_W-1:0]  cx_q, cy_q, cz_q;
	logic [KER_AW-1:0] ki_q;
	logic [ISZ_W-1:0]  sx, sy, sz;
	logic [ADDR_W-1:0] img_ra;
	logic              row_end, plane_end;

	logic                     v_s1, v_s2;
	logic signed [VAL_W-1:0]  img_rd_s1, ker_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     out_vld_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     bad_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_x_q <= IMG_SIZE_RST;
			img_y_q <= IMG_SIZE_RST;
			img_z_q <= IMG_SIZE_RST;
			ker_x_q <= KER_SIZE_RST;
			ker_y_q <= KER_SIZE_RST;
			ker_z_q <= KER_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMG_X: img_x_q <= cfg_data;
				REG_IMG_Y: img_y_q <= cfg_data;
				REG_IMG_Z: img_z_q <= cfg_data;
				REG_KER_X: ker_x_q <= cfg_data[KSZ_W-1:0];
				REG_KER_Y: ker_y_q <= cfg_data[KSZ_W-1:0];
				REG_KER_Z: ker_z_q <= cfg_data[KSZ_W-1:0];
				default:   img_x_q <= img_x_q;
			endcase
		end
	end

	assign nx = (int'(img_x_q) > MAX_IMAGE_DIM) ? ISZ_W'(MAX_IMAGE_DIM) : img_x_q;
	assign ny = (int'(img_y_q) > MAX_IMAGE_DIM) ? ISZ_W'(MAX_IMAGE_DIM) : img_y_q;
	assign nz = (int'(img_z_q) > MAX_IMAGE_DIM) ? ISZ_W'(MAX_IMAGE_DIM) : img_z_q;
	assign kxn = (int'(ker_x_q) > MAX_KERNEL_DIM) ? KSZ_W'(MAX_KERNEL_DIM) : ker_x_q;
	assign kyn = (int'(ker_y_q) > MAX_KERNEL_DIM) ? KSZ_W'(MAX_KERNEL_DIM) : ker_y_q;
	assign kzn = (int'(ker_z_q) > MAX_KERNEL_DIM) ? KSZ_W'(MAX_KERNEL_DIM) : ker_z_q;
	assign hx = kxn >> 1;
	assign hy = kyn >> 1;
	assign hz = kzn >> 1;

	assign bad = !kxn[0] || !kyn[0] || !kzn[0] ||
	             (ISZ_W'(kxn) > nx) || (ISZ_W'(kyn) > ny) || (ISZ_W'(kzn) > nz);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.wr_image && ({1'b0, req_address} < (ADDR_W + 1)'(IMG_DEPTH))) begin
			img_mem[req_address[IMG_AW-1:0]] <= req_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_kernel && ({1'b0, req_address} < (ADDR_W + 1)'(KER_DEPTH))) begin
			ker_mem[req_address[KER_AW-1:0]] <= req_value;
		end
	end

	assign img_ra = ADDR_W'(jx_q) + ADDR_W'(offy_q) + offz_q;

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			img_rd_s1 <= img_mem[img_ra[IMG_AW-1:0]];
			ker_rd_s1 <= ker_mem[ki_q];
		end
	end

	// start of the wrapped walk: (pos + half) mod size
	assign sx = ISZ_W'(wrap_pos(pos_x_q, nx)) + ISZ_W'(hx);
	assign sy = ISZ_W'(wrap_pos(pos_y_q, ny)) + ISZ_W'(hy);
	assign sz = ISZ_W'(wrap_pos(pos_z_q, nz)) + ISZ_W'(hz);

	assign row_end   = (cx_q == kxn - KSZ_W'(1));
	assign plane_end = row_end && (cy_q == kyn - KSZ_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			pos_x_q <= req_pos_x;
			pos_y_q <= req_pos_y;
			pos_z_q <= req_pos_z;
		end
		if (cmd.setup) begin
			jx0_q  <= (sx >= nx) ? POS_W'(sx - nx) : POS_W'(sx);
			jy0_q  <= (sy >= ny) ? POS_W'(sy - ny) : POS_W'(sy);
			jz0_q  <= (sz >= nz) ? POS_W'(sz - nz) : POS_W'(sz);
			nxny_q <= (ISZ_W + POS_W)'(nx) * (ISZ_W + POS_W)'(ny);
		end
		if (cmd.prep) begin
			jx_q    <= jx0_q;
			jy_q    <= jy0_q;
			jz_q    <= jz0_q;
			offy0_q <= OFY_W'(jy0_q) * OFY_W'(nx);
			offy_q  <= OFY_W'(jy0_q) * OFY_W'(nx);
			offyl_q <= OFY_W'(ny - ISZ_W'(1)) * OFY_W'(nx);
			offz_q  <= ADDR_W'(jz0_q) * ADDR_W'(nxny_q);
			offzl_q <= ADDR_W'(nz - ISZ_W'(1)) * ADDR_W'(nxny_q);
			cx_q    <= '0;
			cy_q    <= '0;
			cz_q    <= '0;
			ki_q    <= '0;
		end
		if (cmd.step) begin
			ki_q <= ki_q + KER_AW'(1);
			if (row_end) begin
				cx_q <= '0;
				jx_q <= jx0_q;
			end else begin
				cx_q <= cx_q + KSZ_W'(1);
				jx_q <= (jx_q == '0) ? POS_W'(nx - ISZ_W'(1)) : jx_q - POS_W'(1);
			end
			if (plane_end) begin
				cy_q   <= '0;
				jy_q   <= jy0_q;
				offy_q <= offy0_q;
				cz_q   <= cz_q + KSZ_W'(1);
				jz_q   <= (jz_q == '0) ? POS_W'(nz - ISZ_W'(1)) : jz_q - POS_W'(1);
				offz_q <= (jz_q == '0) ? offzl_q : offz_q - ADDR_W'(nxny_q);
			end else if (row_end) begin
				cy_q   <= cy_q + KSZ_W'(1);
				jy_q   <= (jy_q == '0) ? POS_W'(ny - ISZ_W'(1)) : jy_q - POS_W'(1);
				offy_q <= (jy_q == '0) ? offyl_q : offy_q - OFY_W'(nx);
			end
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= img_rd_s1 * ker_rd_s1;
		end
		if (cmd.setup) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + SUM_W'(prod_s2);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sum_q <= bad ? '0 : acc_q;
			bad_q <= bad;
		end
	end

	assign rsp.valid    = out_vld_q;
	assign rsp.sum      = sum_q;
	assign rsp.bad_size = bad_q;

	assign sts.bad       = bad;
	assign sts.last      = plane_end && (cz_q == kzn - KSZ_W'(1));
	assign sts.pipe_busy = v_s1 || v_s2;
	assign sts.out_busy  = out_vld_q && !rsp.ready;

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("accumulate without a preceding read");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_vld_q)
		else $error("result not presented after finish");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(cmd.finish))
		else $error("result valid without finish");

endmodule

/* rtl/circular_convolution_3d.sv */
// Usage: requests arrive on req (valid/ready); action selects a kernel tap write,
// an image voxel write, or a query at (pos_x, pos_y, pos_z). Writes give no result.
// Each query gives one result on rsp (valid/ready): the circular convolution sum
// as a signed 40-bit integer, or zero with bad_size set when a kernel size is even
// or larger than the image size. Sizes are set through cfg_we/cfg_index/cfg_data
// while idle. Writes are accepted in the idle state. A query occupies the block
// through the setup and prep states, one tap per cycle through the single image
// memory read port and multiplier, a pipeline drain, and a result load; a query
// with bad sizes goes straight from acceptance to the result load.
// Reset restores sizes 16x16x16 and 3x3x3 and empties the result register; the
// memories keep no reset value and must be written before they are read.
// The result register decouples rsp from req: the next request is taken while a
// result waits; when rsp is stalled a following query holds its sum until taken.
module circular_convolution_3d import cc3d_pkg::*; #(
	parameter int MAX_IMAGE_DIM  = MAX_IMAGE_DIM_DEF,
	parameter int MAX_KERNEL_DIM = MAX_KERNEL_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	cc3d_req_if.sink             req,
	cc3d_rsp_if.source           rsp
);

	cmd_t cmd;
	sts_t sts;

	cc3d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	cc3d_dp #(
		.MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
		.MAX_KERNEL_DIM (MAX_KERNEL_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_address (req.address),
		.req_value   (req.value),
		.req_pos_x   (req.pos_x),
		.req_pos_y   (req.pos_y),
		.req_pos_z   (req.pos_z),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

/* tb/circular_convolution_3d_tb.sv */
// Testbench of circular_convolution_3d: directed and random request traffic under changing sizes,
// each result compared with an in-bench wrap-around convolution predictor.
// Depends on cc3d_pkg and on the cc3d_req_if / cc3d_rsp_if interfaces.
module circular_convolution_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cc3d_pkg::*;

	localparam int IMG_DEPTH      = MAX_IMAGE_DIM_DEF ** 3;
	localparam int KER_DEPTH      = MAX_KERNEL_DIM_DEF ** 3;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [ACT_W-1:0]        act;
		logic [ADDR_W-1:0]       addr;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [POS_W-1:0]        pz;
	} conv_req_t;

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic                    bad;
	} conv_result_t;

	typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	cc3d_req_if req_ch();
	cc3d_rsp_if rsp_ch();

	circular_convolution_3d u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic signed [VAL_W-1:0] image_mem [IMG_DEPTH];
	logic signed [VAL_W-1:0] kernel_mem [KER_DEPTH];
	logic [CFG_DAT_W-1:0]    size_reg [6];
	conv_result_t            pending_sums [$];
	conv_result_t            want;

	int       fail_count, items_sent, queries_sent, bad_queries, results_checked, settings_used;
	int       burst_left, holdoff_req, holdoff_left, stall_tick, idle_cycles;
	bit       gaps_on;
	rx_mode_t rx_mode;

	always #5 clk = ~clk;

	function automatic int clamp_dim(int v, int mx);
		return (v > mx) ? mx : v;
	endfunction

	function automatic int wrap_to(int v, int n);
		int r;
		r = v % n;
		return (r < 0) ? r + n : r;
	endfunction

	function automatic int image_volume();
		return clamp_dim(size_reg[REG_IMG_X], MAX_IMAGE_DIM_DEF) *
		       clamp_dim(size_reg[REG_IMG_Y], MAX_IMAGE_DIM_DEF) *
		       clamp_dim(size_reg[REG_IMG_Z], MAX_IMAGE_DIM_DEF);
	endfunction

	function automatic int kernel_volume();
		return clamp_dim(size_reg[REG_KER_X], MAX_KERNEL_DIM_DEF) *
		       clamp_dim(size_reg[REG_KER_Y], MAX_KERNEL_DIM_DEF) *
		       clamp_dim(size_reg[REG_KER_Z], MAX_KERNEL_DIM_DEF);
	endfunction

	function automatic conv_result_t conv_at(logic [POS_W-1:0] qx, logic [POS_W-1:0] qy,
	                                         logic [POS_W-1:0] qz);
		int nx, ny, nz, kxn, kyn, kzn, hx, hy, hz, px, py, pz, jx, jy, jz, ki, ii;
		longint acc;
		conv_result_t r;
		nx  = clamp_dim(size_reg[REG_IMG_X], MAX_IMAGE_DIM_DEF);
		ny  = clamp_dim(size_reg[REG_IMG_Y], MAX_IMAGE_DIM_DEF);
		nz  = clamp_dim(size_reg[REG_IMG_Z], MAX_IMAGE_DIM_DEF);
		kxn = clamp_dim(size_reg[REG_KER_X], MAX_KERNEL_DIM_DEF);
		kyn = clamp_dim(size_reg[REG_KER_Y], MAX_KERNEL_DIM_DEF);
		kzn = clamp_dim(size_reg[REG_KER_Z], MAX_KERNEL_DIM_DEF);
		r.bad = (kxn % 2 == 0) || (kyn % 2 == 0) || (kzn % 2 == 0) ||
		        kxn > nx || kyn > ny || kzn > nz;
		acc = 0;
		if (!r.bad) begin
			hx = (kxn - 1) / 2;
			hy = (kyn - 1) / 2;
			hz = (kzn - 1) / 2;
			px = wrap_to(qx, nx);
			py = wrap_to(qy, ny);
			pz = wrap_to(qz, nz);
			for (int kz = -hz; kz <= hz; kz++) begin
				jz = wrap_to(pz - kz, nz);
				for (int ky = -hy; ky <= hy; ky++) begin
					jy = wrap_to(py - ky, ny);
					for (int kx = -hx; kx <= hx; kx++) begin
						jx = wrap_to(px - kx, nx);
						ki = (kx + hx) + kxn * ((ky + hy) + kyn * (kz + hz));
						ii = jx + nx * (jy + ny * jz);
						acc += longint'(kernel_mem[ki]) * longint'(image_mem[ii]);
					end
				end
			end
		end
		r.sum = r.bad ? '0 : acc[SUM_W-1:0];
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic conv_req_t write_op(logic [ACT_W-1:0] act, int a,
	                                       logic signed [VAL_W-1:0] v);
		conv_req_t it;
		it.act  = act;
		it.addr = ADDR_W'(a);
		it.val  = v;
		it.px   = POS_W'($urandom);
		it.py   = POS_W'($urandom);
		it.pz   = POS_W'($urandom);
		return it;
	endfunction

	function automatic conv_req_t query_op(int x, int y, int z);
		conv_req_t it;
		it.act  = ACT_QUERY;
		it.addr = ADDR_W'($urandom);
		it.val  = VAL_W'($urandom);
		it.px   = POS_W'(x);
		it.py   = POS_W'(y);
		it.pz   = POS_W'(z);
		return it;
	endfunction

	task automatic send_item(input conv_req_t it);
		int gap;
		conv_result_t r;
		@(negedge clk);
		gap = 0;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(1, 6);
			end
			burst_left--;
		end
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.action  = it.act;
		req_ch.address = it.addr;
		req_ch.value   = it.val;
		req_ch.pos_x   = it.px;
		req_ch.pos_y   = it.py;
		req_ch.pos_z   = it.pz;
		req_ch.valid   = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		case (it.act)
			ACT_KERNEL: if (it.addr < KER_DEPTH) kernel_mem[it.addr] = it.val;
			ACT_IMAGE:  image_mem[it.addr] = it.val;
			ACT_QUERY: begin
				r = conv_at(it.px, it.py, it.pz);
				pending_sums.push_back(r);
				queries_sent++;
				if (r.bad) bad_queries++;
			end
			default: ;
		endcase
	endtask

	task automatic drain(input bit settle);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] d);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		size_reg[idx] = (idx >= REG_KER_X) ? CFG_DAT_W'(d[KSZ_W-1:0]) : d;
	endtask

	task automatic set_sizes(input int ix, input int iy, input int iz,
	                         input int kx, input int ky, input int kz);
		drain(1'b1);
		write_reg(REG_IMG_X, CFG_DAT_W'(ix));
		write_reg(REG_IMG_Y, CFG_DAT_W'(iy));
		write_reg(REG_IMG_Z, CFG_DAT_W'(iz));
		write_reg(REG_KER_X, CFG_DAT_W'(kx));
		write_reg(REG_KER_Y, CFG_DAT_W'(ky));
		write_reg(REG_KER_Z, CFG_DAT_W'(kz));
		@(negedge clk);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	task automatic fill_region();
		int kv, iv;
		kv = kernel_volume();
		iv = image_volume();
		for (int a = 0; a < kv; a++) send_item(write_op(ACT_KERNEL, a, pick_value()));
		for (int a = 0; a < iv; a++) send_item(write_op(ACT_IMAGE, a, pick_value()));
	endtask

	task automatic random_traffic(input int n);
		int kv, iv, roll, a;
		conv_req_t it;
		kv = kernel_volume();
		iv = image_volume();
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				it = query_op($urandom_range(0, 15), $urandom_range(0, 15),
				              $urandom_range(0, 15));
			end else if (roll < 65) begin
				a = (iv > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, iv - 1)
				                                          : $urandom_range(0, IMG_DEPTH - 1);
				it = write_op(ACT_IMAGE, a, pick_value());
			end else if (roll < 90) begin
				a = (kv > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, kv - 1)
				                                          : $urandom_range(0, IMG_DEPTH - 1);
				it = write_op(ACT_KERNEL, a, pick_value());
			end else if (roll < 96) begin
				it = write_op(ACT_UNUSED, $urandom_range(0, IMG_DEPTH - 1), VAL_W'($urandom));
			end else begin
				drain(1'b0);
				continue;
			end
			send_item(it);
		end
	endtask

	task automatic run_phase(input int ix, input int iy, input int iz,
	                         input int kx, input int ky, input int kz, input int n);
		set_sizes(ix, iy, iz, kx, ky, kz);
		rx_mode = rx_mode_t'($urandom_range(0, 2));
		gaps_on = ($urandom_range(0, 3) != 0);
		fill_region();
		random_traffic(n);
	endtask

	function automatic int odd_within(int n);
		int m;
		m = (n > MAX_KERNEL_DIM_DEF) ? MAX_KERNEL_DIM_DEF : n;
		return 2 * $urandom_range(0, (m - 1) / 2) + 1;
	endfunction

	task automatic test_single_voxel();
		set_sizes(1, 1, 1, 1, 1, 1);
		send_item(write_op(ACT_KERNEL, 0, 16'sh8000));
		send_item(write_op(ACT_IMAGE, 0, 16'sh8000));
		send_item(query_op(15, 15, 15));
		send_item(write_op(ACT_IMAGE, 0, 16'sh7fff));
		send_item(query_op(0, 0, 0));
		send_item(write_op(ACT_KERNEL, KER_DEPTH, 16'sh1234));
		send_item(write_op(ACT_KERNEL, IMG_DEPTH - 1, 16'sh7fff));
		send_item(write_op(ACT_UNUSED, 0, '0));
		send_item(query_op(7, 0, 9));
	endtask

	task automatic test_wrap_line();
		set_sizes(3, 1, 1, 3, 1, 1);
		for (int a = 0; a < 3; a++) send_item(write_op(ACT_KERNEL, a, pick_value()));
		for (int a = 0; a < 3; a++) send_item(write_op(ACT_IMAGE, a, pick_value()));
		send_item(query_op(0, 0, 0));
		send_item(query_op(2, 5, 3));
		send_item(query_op(15, 0, 0));
	endtask

	task automatic test_bad_sizes();
		set_sizes(4, 4, 4, 2, 1, 1);
		send_item(query_op(1, 1, 1));
		set_sizes(2, 2, 2, 3, 1, 1);
		send_item(query_op(0, 0, 0));
		set_sizes(0, 5, 5, 1, 1, 1);
		send_item(query_op(0, 2, 4));
		set_sizes(5, 5, 5, 1, 0, 1);
		send_item(query_op(4, 4, 4));
	endtask

	task automatic test_oversized_image();
		set_sizes(31, 1, 1, 1, 1, 1);
		send_item(write_op(ACT_IMAGE, 15, 16'sh7fff));
		send_item(write_op(ACT_IMAGE, 3, 16'sh8000));
		send_item(query_op(15, 0, 0));
		send_item(query_op(3, 9, 14));
	endtask

	task automatic test_extreme_sizes();
		run_phase(16, 1, 1, 7, 1, 1, 60);
		run_phase(1, 16, 1, 1, 7, 1, 60);
		run_phase(2, 2, 16, 1, 1, 7, 60);
		run_phase(7, 7, 2, 7, 7, 1, 40);
		run_phase(1, 20, 1, 1, 5, 1, 30);
		run_phase(1, 1, 31, 1, 1, 3, 30);
	endtask

	task automatic test_random_sizes();
		int ix, iy, iz, kx, ky, kz;
		for (int p = 0; p < 8; p++) begin
			ix = $urandom_range(1, 6);
			iy = $urandom_range(1, 6);
			iz = $urandom_range(1, 6);
			kx = odd_within(ix);
			ky = odd_within(iy);
			kz = odd_within(iz);
			case ($urandom_range(0, 9))
				0: kx = 2 * $urandom_range(0, 3);
				1: iz = 0;
				2: ky = (iy + 1) | 1;
				default: ;
			endcase
			run_phase(ix, iy, iz, kx, ky, kz, 100);
		end
	endtask

	task automatic test_backpressure();
		set_sizes(3, 3, 3, 1, 1, 1);
		rx_mode = RX_STEADY;
		gaps_on = 1'b0;
		fill_region();
		holdoff_req = 300;
		for (int i = 0; i < 40; i++)
			send_item(query_op($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15)));
		gaps_on = 1'b1;
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req > 0) begin
				holdoff_left = holdoff_req;
				holdoff_req  = 0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				rsp_ch.ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_STEADY:   rsp_ch.ready = 1'b1;
					RX_RANDOM:   rsp_ch.ready = ($urandom_range(0, 9) >= 3);
					RX_PERIODIC: begin
						stall_tick++;
						rsp_ch.ready = ((stall_tick % 11) < 6);
					end
					default:     rsp_ch.ready = 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_sums.size() == 0) begin
				$error("result with nothing expected: sum %0d, bad_size %0b",
				       rsp_ch.sum, rsp_ch.bad_size);
				fail_count++;
			end else begin
				want = pending_sums.pop_front();
				results_checked++;
				if (rsp_ch.sum !== want.sum) begin
					$error("sum: expected %0d, got %0d", want.sum, rsp_ch.sum);
					fail_count++;
				end
				if (rsp_ch.bad_size !== want.bad) begin
					$error("bad_size: expected %0b, got %0b", want.bad, rsp_ch.bad_size);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$error("watchdog: no transaction for %0d cycles, %0d results outstanding",
			       idle_cycles, pending_sums.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_IMG_X;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.action  = ACT_KERNEL;
		req_ch.address = '0;
		req_ch.value   = '0;
		req_ch.pos_x   = '0;
		req_ch.pos_y   = '0;
		req_ch.pos_z   = '0;
		gaps_on        = 1'b1;
		size_reg[REG_IMG_X] = IMG_SIZE_RST;
		size_reg[REG_IMG_Y] = IMG_SIZE_RST;
		size_reg[REG_IMG_Z] = IMG_SIZE_RST;
		size_reg[REG_KER_X] = CFG_DAT_W'(KER_SIZE_RST);
		size_reg[REG_KER_Y] = CFG_DAT_W'(KER_SIZE_RST);
		size_reg[REG_KER_Z] = CFG_DAT_W'(KER_SIZE_RST);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_voxel();
		test_wrap_line();
		test_bad_sizes();
		test_oversized_image();
		test_extreme_sizes();
		test_random_sizes();
		test_backpressure();
		drain(1'b1);

		$display("Sent %0d request transactions (%0d queries, %0d with illegal sizes)",
		         items_sent, queries_sent, bad_queries);
		$display("over %0d size settings; compared %0d results, %0d mismatches.",
		         settings_used, results_checked, fail_count);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
